/* hw/rtl/power_panel_can_status_decoder_core_defines.svh */
// assertion macros shared by the decoder checker
`ifndef POWER_PANEL_CAN_STATUS_DECODER_CORE_DEFINES_SVH
`define POWER_PANEL_CAN_STATUS_DECODER_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define PPCSD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("ppcsd check failed");

// next-cycle implication, held off during reset
`define PPCSD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("ppcsd check failed");

`endif

/* hw/rtl/ppcsd_pkg.sv */
// types, constants and helpers of the panel status decoder
package ppcsd_pkg;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned DATA_W    = 64;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned DEV_W     = 6;
  localparam int unsigned CUR_W     = 10;
  localparam int unsigned VOLT_W    = 13;
  localparam int unsigned NUM_GROUPS = 3;
  localparam int unsigned GROUP_W   = 2;
  localparam int unsigned WORD_W    = 3;

  localparam logic [ID_W-1:0] CUR_MASK = 29'h8041400;
  localparam int unsigned GROUP_LSB = 6;
  localparam logic [GROUP_W-1:0] GROUP_IGNORED = 2'd3;
  localparam logic [GROUP_W-1:0] GROUP_VOLT    = 2'd2;

  // floor(raw * 4096 / 3444) == (raw * VOLT_RECIP) >> VOLT_SHIFT for every raw below 4336
  localparam int unsigned RAW_W      = 13;
  localparam int unsigned RECIP_W    = 23;
  localparam int unsigned PROD_W     = RAW_W + RECIP_W;
  localparam logic [RECIP_W-1:0] VOLT_RECIP = 23'd4988348;
  localparam int unsigned VOLT_SHIFT = 22;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_DEVICE_ID = 1'b0;
  localparam int unsigned APB_DATA_W = 32;

  typedef enum logic [0:0] {
    OP_FRAME = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    logic              opcode;
    logic [ID_W-1:0]   frame_id;
    logic [DATA_W-1:0] frame_data;
    logic [CHAN_W-1:0] channel;
  } item_t;

  typedef struct packed {
    logic                  accepted;
    logic [VOLT_W-1:0]     voltage;
    logic [NUM_GROUPS-1:0] fresh;
  } status_t;

  typedef struct packed {
    logic                  frame_accepted;
    logic [CUR_W-1:0]      current_eighths;
    logic [VOLT_W-1:0]     bus_voltage_q12;
    logic [NUM_GROUPS-1:0] fresh_flags;
  } result_t;

  typedef logic [DATA_W-1:0] cache_arr_t [NUM_GROUPS];

  // packed 10-bit reading of one word in a cached payload
  function automatic logic [CUR_W-1:0] unpack_word(logic [DATA_W-1:0] c,
                                                    logic [WORD_W-1:0] w);
    logic [CUR_W-1:0] r;
    case (w)
      3'd0:    r = {c[7:0],   c[15:14]};
      3'd1:    r = {c[13:8],  c[23:20]};
      3'd2:    r = {c[19:16], c[31:26]};
      3'd3:    r = {c[25:24], c[39:32]};
      3'd4:    r = {c[47:40], c[55:54]};
      default: r = {c[53:48], c[63:60]};
    endcase
    return r;
  endfunction

endpackage

/* hw/rtl/ppcsd_if.sv */
// word channels of the panel status decoder
interface ppcsd_in_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [ppcsd_pkg::ID_W-1:0]    frame_id;
  logic [ppcsd_pkg::DATA_W-1:0]  frame_data;
  logic [ppcsd_pkg::CHAN_W-1:0]  channel;

  modport source (output valid, opcode, frame_id, frame_data, channel, input ready);
  modport sink   (input valid, opcode, frame_id, frame_data, channel, output ready);
endinterface

interface ppcsd_out_if;
  logic                              valid;
  logic                              ready;
  logic                              frame_accepted;
  logic [ppcsd_pkg::CUR_W-1:0]       current_eighths;
  logic [ppcsd_pkg::VOLT_W-1:0]      bus_voltage_q12;
  logic [ppcsd_pkg::NUM_GROUPS-1:0]  fresh_flags;

  modport source (output valid, frame_accepted, current_eighths, bus_voltage_q12,
                  fresh_flags, input ready);
  modport sink   (input valid, frame_accepted, current_eighths, bus_voltage_q12,
                  fresh_flags, output ready);
endinterface

/* hw/rtl/power_panel_can_status_decoder_core.sv */
// top level of the power panel CAN status decoder
//
// in_ch carries one word per item: a received CAN frame (opcode 0) or a
// channel current query (opcode 1). out_ch returns exactly one result word
// per item: frame accepted flag, queried current in eighths of an amp, bus
// voltage with 12 fractional bits and the three group fresh flags.
// device_id is written over the APB port at byte address 0; the user must
// do so only while idle, the block does not enforce it. An accepted word
// lands in the input register; once the result register can take it, the
// filter, cache update, voltage multiply and channel unpack run in one pass
// into the result register. Throughput is one item per cycle while out_ch
// does not stall, bounded by the single pass from input to result register.
// Reset clears caches, fresh flags, voltage and device_id, and empties both
// registers. When the receiver stalls, the result register holds; the input
// register takes one more word and then ready drops until out_ch drains.
module power_panel_can_status_decoder_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ppcsd_in_if.sink                          in_ch,
  ppcsd_out_if.source                       out_ch,
  input  logic                              psel_i,
  input  logic                              penable_i,
  input  logic                              pwrite_i,
  input  logic [ppcsd_pkg::CFG_ADDR_W-1:0]  paddr_i,
  input  logic [ppcsd_pkg::APB_DATA_W-1:0]  pwdata_i,
  output logic [ppcsd_pkg::APB_DATA_W-1:0]  prdata_o,
  output logic                              pready_o
);
  import ppcsd_pkg::*;

  logic                 in_valid_q, in_valid_d;
  item_t                item_q;
  logic                 out_valid_q, out_valid_d;
  result_t              result_q;
  logic [DEV_W-1:0]     device_id_q;
  logic                 in_ready;
  logic                 in_fire;
  logic                 fire;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_idx;
  status_t              status;
  cache_arr_t           cache;
  logic [CUR_W-1:0]     current;

  assign fire     = in_valid_q && (!out_valid_q || out_ch.ready);
  assign in_ready = !in_valid_q || fire;
  assign in_fire  = in_ch.valid && in_ready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_fire) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.opcode     <= in_ch.opcode;
      item_q.frame_id   <= in_ch.frame_id;
      item_q.frame_data <= in_ch.frame_data;
      item_q.channel    <= in_ch.channel;
    end
    if (fire) begin
      result_q.frame_accepted  <= status.accepted;
      result_q.current_eighths <= (item_q.opcode == OP_QUERY) ? current : '0;
      result_q.bus_voltage_q12 <= status.voltage;
      result_q.fresh_flags     <= status.fresh;
    end
  end

  ppcsd_cache u_cache (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .item_i      (item_q),
    .device_id_i (device_id_q),
    .status_o    (status),
    .cache_o     (cache)
  );

  ppcsd_unpack u_unpack (
    .cache_i   (cache),
    .channel_i (item_q.channel),
    .current_o (current)
  );

  // configuration port
  assign pready_o  = 1'b1;
  assign cfg_idx   = paddr_i[CFG_ADDR_W-1 -: CFG_IDX_W];
  assign cfg_write = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      device_id_q <= '0;
    end else if (cfg_write && (cfg_idx == CFG_IDX_DEVICE_ID)) begin
      device_id_q <= pwdata_i[DEV_W-1:0];
    end
  end

  assign prdata_o = (cfg_idx == CFG_IDX_DEVICE_ID) ?
                    {{(APB_DATA_W-DEV_W){1'b0}}, device_id_q} : '0;

  assign in_ch.ready            = in_ready;
  assign out_ch.valid           = out_valid_q;
  assign out_ch.frame_accepted  = result_q.frame_accepted;
  assign out_ch.current_eighths = result_q.current_eighths;
  assign out_ch.bus_voltage_q12 = result_q.bus_voltage_q12;
  assign out_ch.fresh_flags     = result_q.fresh_flags;

endmodule

/* hw/rtl/ppcsd_cache.sv */
// frame filter, payload caches, fresh flags and bus voltage register
module ppcsd_cache (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         fire_i,
  input  ppcsd_pkg::item_t             item_i,
  input  logic [ppcsd_pkg::DEV_W-1:0]  device_id_i,
  output ppcsd_pkg::status_t           status_o,
  output ppcsd_pkg::cache_arr_t        cache_o
);
  import ppcsd_pkg::*;

  logic [DATA_W-1:0]     cache_q [NUM_GROUPS];
  logic [DATA_W-1:0]     cache_d [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] fresh_q, fresh_d;
  logic [VOLT_W-1:0]     volt_q, volt_d;

  logic                  pass;
  logic                  store;
  logic [GROUP_W-1:0]    sel;
  logic [RAW_W-1:0]      raw;
  logic [PROD_W-1:0]     prod;

  always_comb begin
    pass  = ((item_i.frame_id[DEV_W-1:0] & device_id_i) == device_id_i) &&
            ((item_i.frame_id & CUR_MASK) == CUR_MASK);
    sel   = item_i.frame_id[GROUP_LSB +: GROUP_W];
    store = fire_i && (item_i.opcode == OP_FRAME) && pass && (sel != GROUP_IGNORED);

    // raw = byte6 * 16 + byte7
    raw  = {1'b0, item_i.frame_data[55:48], 4'b0000} +
           {{(RAW_W-8){1'b0}}, item_i.frame_data[63:56]};
    prod = {{RECIP_W{1'b0}}, raw} * {{RAW_W{1'b0}}, VOLT_RECIP};

    fresh_d = fresh_q;
    volt_d  = volt_q;
    for (int i = 0; i < NUM_GROUPS; i++) begin
      cache_d[i] = cache_q[i];
      if (store && (sel == GROUP_W'(i))) begin
        cache_d[i] = item_i.frame_data;
        fresh_d[i] = 1'b1;
      end
    end
    if (store && (sel == GROUP_VOLT)) begin
      volt_d = prod[VOLT_SHIFT +: VOLT_W];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_GROUPS; i++) begin
        cache_q[i] <= '0;
      end
      fresh_q <= '0;
      volt_q  <= '0;
    end else begin
      cache_q <= cache_d;
      fresh_q <= fresh_d;
      volt_q  <= volt_d;
    end
  end

  assign status_o.accepted = store;
  assign status_o.voltage  = volt_d;
  assign status_o.fresh    = fresh_d;
  assign cache_o           = cache_q;

endmodule

/* hw/rtl/ppcsd_unpack.sv */
// picks the cache and packed word of a queried channel
module ppcsd_unpack (
  input  ppcsd_pkg::cache_arr_t        cache_i,
  input  logic [ppcsd_pkg::CHAN_W-1:0] channel_i,
  output logic [ppcsd_pkg::CUR_W-1:0]  current_o
);
  import ppcsd_pkg::*;

  logic [DATA_W-1:0] word_src;
  logic [CHAN_W-1:0] offset;

  always_comb begin
    unique case (channel_i) inside
      [4'd0:4'd5]: begin
        word_src = cache_i[0];
        offset   = 4'd0;
      end
      [4'd6:4'd11]: begin
        word_src = cache_i[1];
        offset   = 4'd6;
      end
      default: begin
        word_src = cache_i[2];
        offset   = 4'd12;
      end
    endcase
    current_o = unpack_word(word_src, WORD_W'(channel_i - offset));
  end

endmodule

/* hw/rtl/ppcsd_checker.sv */
// port-level checks of the panel status decoder and their bind
`include "power_panel_can_status_decoder_core_defines.svh"

module ppcsd_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_ready_i,
  input logic                                 out_valid_i,
  input logic                                 out_ready_i,
  input logic                                 out_frame_accepted_i,
  input logic [ppcsd_pkg::CUR_W-1:0]          out_current_eighths_i,
  input logic [ppcsd_pkg::VOLT_W-1:0]         out_bus_voltage_q12_i,
  input logic [ppcsd_pkg::NUM_GROUPS-1:0]     out_fresh_flags_i,
  input logic                                 psel_i,
  input logic                                 penable_i,
  input logic                                 pwrite_i,
  input logic [ppcsd_pkg::CFG_ADDR_W-1:0]     paddr_i,
  input logic [ppcsd_pkg::APB_DATA_W-1:0]     pwdata_i,
  input logic [ppcsd_pkg::APB_DATA_W-1:0]     prdata_i
);
  import ppcsd_pkg::*;

  // a stalled result word holds
  `PPCSD_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_current_eighths_i) && $stable(out_bus_voltage_q12_i) && $stable(out_fresh_flags_i) && $stable(out_frame_accepted_i))

  // with the result register empty the input side never stalls
  `PPCSD_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_i, in_ready_i || !in_valid_i || in_ready_i)

  // fresh flags only ever get set from one result to the next
  `PPCSD_ASSERT_NEXT(a_fresh_sticky, clk_i, rst_ni, out_valid_i && out_ready_i, !out_valid_i || ((out_fresh_flags_i & $past(out_fresh_flags_i)) == $past(out_fresh_flags_i)))

  // a stored frame marks its group and carries no current
  `PPCSD_ASSERT_NOW(a_accept_fields, clk_i, rst_ni, out_valid_i && out_frame_accepted_i, (out_fresh_flags_i != '0) && (out_current_eighths_i == '0))

  // device_id reads back what was written
  `PPCSD_ASSERT_NEXT(a_cfg_readback, clk_i, rst_ni, psel_i && penable_i && pwrite_i && (paddr_i[CFG_ADDR_W-1 -: CFG_IDX_W] == CFG_IDX_DEVICE_ID), (paddr_i[CFG_ADDR_W-1 -: CFG_IDX_W] != CFG_IDX_DEVICE_ID) || (prdata_i == {{(APB_DATA_W-DEV_W){1'b0}}, $past(pwdata_i[DEV_W-1:0])}))

endmodule

bind power_panel_can_status_decoder_core ppcsd_checker u_ppcsd_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_ch.valid),
  .in_ready_i            (in_ch.ready),
  .out_valid_i           (out_ch.valid),
  .out_ready_i           (out_ch.ready),
  .out_frame_accepted_i  (out_ch.frame_accepted),
  .out_current_eighths_i (out_ch.current_eighths),
  .out_bus_voltage_q12_i (out_ch.bus_voltage_q12),
  .out_fresh_flags_i     (out_ch.fresh_flags),
  .psel_i                (psel_i),
  .penable_i             (penable_i),
  .pwrite_i              (pwrite_i),
  .paddr_i               (paddr_i),
  .pwdata_i              (pwdata_i),
  .prdata_i              (prdata_o)
);
